FILE: src/ptm_pkg.sv
// ----------------------------------------------------------------------------
// ptm_pkg
// Shared codes and types of the page table map and translate block.
// ----------------------------------------------------------------------------
package ptm_pkg;

  // request types
  localparam logic [1:0] REQ_MAP       = 2'd0;
  localparam logic [1:0] REQ_LOOKUP    = 2'd1;
  localparam logic [1:0] REQ_TRANSLATE = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_MISALIGNED = 2'd1;
  localparam logic [1:0] ST_OUTSIDE    = 2'd2;

  // register index (word address bit of paddr)
  localparam logic REG_DEFAULT_FLAGS = 1'b0;

  // depth of the queue between front and back end
  localparam int QUEUE_DEPTH = 2;

  // what the back end has to do with a queued command
  typedef enum logic [1:0] {
    CMD_DONE,
    CMD_MAP,
    CMD_READ
  } ptm_kind_t;

  // classified command
  typedef struct packed {
    ptm_kind_t   kind;
    logic [1:0]  status;
    logic [31:0] virt;
    logic [31:0] phys;
    logic [10:0] count;
    logic [11:0] flags;
  } ptm_cmd_t;

  // command together with its valid flag
  typedef struct packed {
    logic     valid;
    ptm_cmd_t cmd;
  } ptm_slot_t;

endpackage

FILE: src/ptm_front.sv
// ----------------------------------------------------------------------------
// ptm_front
// Accepts request transactions, checks alignment and table range, and
// pushes a classified command into the queue.
// ----------------------------------------------------------------------------
module ptm_front #(
  parameter int PAGE_OFFSET_BITS = 12,
  parameter int TABLE_PAGES      = 1024
) (
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          req_type,
  input  logic [31:0]         virt_addr,
  input  logic [31:0]         phys_addr,
  input  logic [10:0]         page_count,
  input  logic [11:0]         page_flags,
  input  logic                q_full,
  input  logic                clearing,
  output ptm_pkg::ptm_slot_t  push
);
  import ptm_pkg::*;

  localparam logic [31:0] TABLE_PAGES_W = 32'(TABLE_PAGES);

  logic        virt_mis;
  logic        phys_mis;
  logic [31:0] vpn;
  logic        in_table;
  ptm_cmd_t    cmd;

  // alignment and range checks
  assign virt_mis = virt_addr[PAGE_OFFSET_BITS-1:0] != '0;
  assign phys_mis = phys_addr[PAGE_OFFSET_BITS-1:0] != '0;
  assign vpn      = virt_addr >> PAGE_OFFSET_BITS;
  assign in_table = vpn < TABLE_PAGES_W;

  // classify the request
  always_comb begin
    cmd.kind   = CMD_DONE;
    cmd.status = ST_OK;
    cmd.virt   = virt_addr;
    cmd.phys   = phys_addr;
    cmd.count  = page_count;
    cmd.flags  = page_flags;
    unique case (req_type)
      REQ_MAP: begin
        if (virt_mis || phys_mis) begin
          cmd.status = ST_MISALIGNED;
        end else begin
          cmd.kind = CMD_MAP;
        end
      end
      REQ_LOOKUP, REQ_TRANSLATE: begin
        if (req_type == REQ_LOOKUP && virt_mis) begin
          cmd.status = ST_MISALIGNED;
        end else if (!in_table) begin
          cmd.status = ST_OUTSIDE;
        end else begin
          cmd.kind = CMD_READ;
        end
      end
      default: begin
        cmd.kind = CMD_DONE;
      end
    endcase
  end

  // handshake into the queue, held off while the written bits are swept
  assign in_ready   = !q_full && !clearing;
  assign push.valid = in_valid && in_ready;
  assign push.cmd   = cmd;

endmodule

FILE: src/ptm_queue.sv
// ----------------------------------------------------------------------------
// ptm_queue
// Short command queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module ptm_queue (
  input  logic                clk,
  input  logic                rst,
  input  ptm_pkg::ptm_slot_t  push,
  input  logic                pop,
  output ptm_pkg::ptm_slot_t  head,
  output logic                full
);
  import ptm_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

  ptm_cmd_t          slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  fill;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push.valid && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push.valid) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push.valid) begin
      slots[wr_ptr] <= push.cmd;
    end
  end

  assign head.valid = fill != '0;
  assign head.cmd   = slots[rd_ptr];
  assign full       = fill == DEPTH_C;

endmodule

FILE: src/ptm_back.sv
// ----------------------------------------------------------------------------
// ptm_back
// Executes queued commands against the page table memories and holds the
// result register.
// ----------------------------------------------------------------------------
module ptm_back #(
  parameter int PAGE_OFFSET_BITS = 12,
  parameter int TABLE_PAGES      = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  ptm_pkg::ptm_slot_t  head,
  output logic                pop,
  output logic                clearing,
  input  logic [7:0]          default_flags,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          status,
  output logic [31:0]         entry_value,
  output logic [31:0]         phys_out
);
  import ptm_pkg::*;

  localparam int          IDX_W         = $clog2(TABLE_PAGES);
  localparam logic [31:0] TABLE_PAGES_W = 32'(TABLE_PAGES);
  localparam logic [31:0] PAGE_SIZE     = 32'd1 << PAGE_OFFSET_BITS;
  localparam logic [31:0] FRAME_MASK    = ~(PAGE_SIZE - 32'd1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_PAGES - 1);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_MAP,
    S_READ_WAIT
  } state_t;

  state_t            state;
  logic [IDX_W-1:0]  clr_idx;
  logic [31:0]       virt;
  logic [31:0]       phys;
  logic [10:0]       count;
  logic [11:0]       flags;

  logic [31:0]       entries_mem [TABLE_PAGES];
  logic              written_mem [TABLE_PAGES];
  logic [31:0]       rd_entry;
  logic              rd_written;

  logic              out_free;
  logic [31:0]       head_vpn;
  logic [IDX_W-1:0]  rd_idx;
  logic [31:0]       map_vpn;
  logic [IDX_W-1:0]  map_idx;
  logic              map_in_table;
  logic              map_write;
  logic [31:0]       read_entry;
  logic [31:0]       read_phys;

  // command pop and memory addressing
  assign out_free     = !out_valid || out_ready;
  assign pop          = (state == S_IDLE) && head.valid && out_free;
  assign clearing     = state == S_CLEAR;
  assign head_vpn     = head.cmd.virt >> PAGE_OFFSET_BITS;
  assign rd_idx       = head_vpn[IDX_W-1:0];
  assign map_vpn      = virt >> PAGE_OFFSET_BITS;
  assign map_idx      = map_vpn[IDX_W-1:0];
  assign map_in_table = map_vpn < TABLE_PAGES_W;
  assign map_write    = (state == S_MAP) && (count != '0) && map_in_table;

  // entry memory, undefined until written
  always_ff @(posedge clk) begin
    if (map_write) begin
      entries_mem[map_idx] <= phys | {20'b0, flags};
    end
    rd_entry <= entries_mem[rd_idx];
  end

  // written-bit memory, swept clear after reset
  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      written_mem[clr_idx] <= 1'b0;
    end else if (map_write) begin
      written_mem[map_idx] <= 1'b1;
    end
    rd_written <= written_mem[rd_idx];
  end

  // unwritten entries read as identity mappings
  always_comb begin
    read_entry = rd_written ? rd_entry : ((virt & FRAME_MASK) | {24'b0, default_flags});
    read_phys  = (read_entry & FRAME_MASK) + (virt & ~FRAME_MASK);
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == LAST_IDX) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (pop) begin
            virt  <= head.cmd.virt;
            phys  <= head.cmd.phys;
            count <= head.cmd.count;
            flags <= head.cmd.flags;
            unique case (head.cmd.kind)
              CMD_MAP: begin
                state <= S_MAP;
              end
              CMD_READ: begin
                state <= S_READ_WAIT;
              end
              default: begin
                out_valid   <= 1'b1;
                status      <= head.cmd.status;
                entry_value <= '0;
                phys_out    <= '0;
              end
            endcase
          end
        end
        S_MAP: begin
          if (count == '0) begin
            out_valid   <= 1'b1;
            status      <= ST_OK;
            entry_value <= '0;
            phys_out    <= '0;
            state       <= S_IDLE;
          end else if (!map_in_table) begin
            out_valid   <= 1'b1;
            status      <= ST_OUTSIDE;
            entry_value <= '0;
            phys_out    <= '0;
            state       <= S_IDLE;
          end else begin
            virt  <= virt + PAGE_SIZE;
            phys  <= phys + PAGE_SIZE;
            count <= count - 11'd1;
          end
        end
        S_READ_WAIT: begin
          out_valid   <= 1'b1;
          status      <= ST_OK;
          entry_value <= read_entry;
          phys_out    <= read_phys;
          state       <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_pop_needs_free_output: assert property (@(posedge clk) disable iff (rst)
    pop |-> (!out_valid || out_ready))
    else $error("command popped while result register is occupied");

  a_read_gives_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ_WAIT) |=> (out_valid && state == S_IDLE))
    else $error("read did not produce a result");

  a_map_counts_down: assert property (@(posedge clk) disable iff (rst)
    (state == S_MAP && $past(state) == S_MAP) |-> (count == $past(count) - 11'd1))
    else $error("map page count did not step");

  a_no_write_while_clearing: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> (!map_write && !pop))
    else $error("table access during clearing pass");
`endif

endmodule

FILE: src/page_table_map_and_translate.sv
// ----------------------------------------------------------------------------
// page_table_map_and_translate
// Flat page table store: maps page ranges, looks up raw entries and
// translates virtual addresses.
// ----------------------------------------------------------------------------
//  channel  | handshake               | fields
//  request  | in_valid / in_ready     | req_type virt_addr phys_addr
//           |                         | page_count page_flags
//  result   | out_valid / out_ready   | status entry_value phys_out
//  config   | psel penable pwrite     | paddr pwdata prdata pready
//
//  lookup and translate pass through S_READ_WAIT in the back end: one registered
//  read of the entry and written-bit memories.
//  a map writes one entry per cycle until page_count runs out or the page leaves the table.
//  after reset the written bits are swept clear, one entry after another;
//  in_ready stays low during that sweep, config writes are taken.
//  a two-entry command queue keeps taking requests while a result waits.
// ----------------------------------------------------------------------------
module page_table_map_and_translate #(
  parameter int PAGE_OFFSET_BITS = 12,
  parameter int TABLE_PAGES      = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [31:0] virt_addr,
  input  logic [31:0] phys_addr,
  input  logic [10:0] page_count,
  input  logic [11:0] page_flags,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] entry_value,
  output logic [31:0] phys_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ptm_pkg::*;

  logic       [7:0] default_flags;
  ptm_slot_t        push;
  ptm_slot_t        head;
  logic             q_full;
  logic             pop;
  logic             clearing;

  // configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_flags <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_DEFAULT_FLAGS) begin
      default_flags <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == REG_DEFAULT_FLAGS) ? {24'b0, default_flags} : 32'b0;

  // front end: accept and classify
  ptm_front #(
    .PAGE_OFFSET_BITS (PAGE_OFFSET_BITS),
    .TABLE_PAGES      (TABLE_PAGES)
  ) u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .virt_addr  (virt_addr),
    .phys_addr  (phys_addr),
    .page_count (page_count),
    .page_flags (page_flags),
    .q_full     (q_full),
    .clearing   (clearing),
    .push       (push)
  );

  // command queue
  ptm_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (head),
    .full (q_full)
  );

  // back end: table memories and results
  ptm_back #(
    .PAGE_OFFSET_BITS (PAGE_OFFSET_BITS),
    .TABLE_PAGES      (TABLE_PAGES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .pop           (pop),
    .clearing      (clearing),
    .default_flags (default_flags),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .entry_value   (entry_value),
    .phys_out      (phys_out)
  );

`ifndef ASSERT_OFF
  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !in_ready)
    else $error("request accepted during clearing pass");
`endif

endmodule
